/* design/mbpf_pkg.sv */
// Shared types and constants of the median baseline pulse finder.
package mbpf_pkg;

  localparam int unsigned WINDOW_MAX_DEF  = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_AFTER    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INDEX_OFFSET = 3'd4;

  localparam logic [2:0] STAT_QUIET_END = 3'd0;
  localparam logic [2:0] STAT_LEN_LIMIT = 3'd1;
  localparam logic [2:0] STAT_DATA_END  = 3'd2;
  localparam logic [2:0] STAT_NO_PULSE  = 3'd3;
  localparam logic [2:0] STAT_FILL_END  = 3'd4;

  // Control from the sequencer to the sorted chain.
  typedef struct packed {
    logic upd;
    logic flush;
    logic evict;
  } chain_ctl_t;

  // Flags a cell shows its neighbors.
  typedef struct packed {
    logic valid;
    logic gt;
    logic old;
  } cell_flg_t;

endpackage

/* design/mbpf_cell.sv */
// One cell of the sorted window chain: a value, its age and a valid bit.
module mbpf_cell import mbpf_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned AGE_BITS    = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  chain_ctl_t                    ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [AGE_BITS-1:0]           evict_age_i,
  input  logic                          valid_next_i,
  input  logic signed [SAMPLE_BITS-1:0] l_val_i,
  input  logic [AGE_BITS-1:0]           l_age_i,
  input  cell_flg_t                     l_flg_i,
  input  logic signed [SAMPLE_BITS-1:0] r_val_i,
  input  logic [AGE_BITS-1:0]           r_age_i,
  input  cell_flg_t                     r_flg_i,
  input  logic                          rem_i,
  output logic signed [SAMPLE_BITS-1:0] val_o,
  output logic [AGE_BITS-1:0]           age_o,
  output cell_flg_t                     flg_o,
  output logic                          rem_o
);

  logic                          valid_q, valid_d;
  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AGE_BITS-1:0]           age_q, age_d;
  logic gt, old, from_left, from_self, from_right;

  assign gt    = valid_q && (val_q > sample_i);
  assign old   = valid_q && ctl_i.evict && (age_q == evict_age_i);
  assign flg_o = '{valid: valid_q, gt: gt, old: old};
  assign rem_o = rem_i | old;
  assign val_o = val_q;
  assign age_o = age_q;

  // Kept entries move down by one if an entry below is removed, up by one if
  // the new sample lands below them.
  assign from_left  = l_flg_i.valid && l_flg_i.gt && !l_flg_i.old && !rem_i;
  assign from_self  = valid_q && !old && (rem_i == gt);
  assign from_right = rem_o && r_flg_i.valid && !r_flg_i.gt && !r_flg_i.old;

  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    age_d   = age_q;
    if (ctl_i.flush) begin
      valid_d = 1'b0;
    end else if (ctl_i.upd) begin
      valid_d = valid_next_i;
      if (from_left) begin
        val_d = l_val_i;
        age_d = l_age_i + 1'b1;
      end else if (from_self) begin
        age_d = age_q + 1'b1;
      end else if (from_right) begin
        val_d = r_val_i;
        age_d = r_age_i + 1'b1;
      end else begin
        val_d = sample_i;
        age_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
  end

endmodule

/* design/mbpf_chain.sv */
// Row of sorted window cells with the median tap.
module mbpf_chain import mbpf_pkg::*; #(
  parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned AGE_BITS    = 5,
  parameter int unsigned CNT_BITS    = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  chain_ctl_t                    ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [AGE_BITS-1:0]           evict_age_i,
  input  logic [CNT_BITS-1:0]           new_cnt_i,
  input  logic [AGE_BITS-1:0]           med_idx_i,
  output logic signed [SAMPLE_BITS-1:0] med_val_o
);

  logic signed [SAMPLE_BITS-1:0] val   [WINDOW_MAX];
  logic [AGE_BITS-1:0]           age   [WINDOW_MAX];
  cell_flg_t                     flg   [WINDOW_MAX];
  logic                          rem   [WINDOW_MAX];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] l_val, r_val;
    logic [AGE_BITS-1:0]           l_age, r_age;
    cell_flg_t                     l_flg, r_flg;
    logic                          rem_in;
    logic                          valid_next;

    assign valid_next = (32'(i) < 32'(new_cnt_i));

    if (i == 0) begin : g_first
      assign l_val  = '0;
      assign l_age  = '0;
      assign l_flg  = '0;
      assign rem_in = 1'b0;
    end else begin : g_mid
      assign l_val  = val[i-1];
      assign l_age  = age[i-1];
      assign l_flg  = flg[i-1];
      assign rem_in = rem[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign r_val = '0;
      assign r_age = '0;
      assign r_flg = '0;
    end else begin : g_inner
      assign r_val = val[i+1];
      assign r_age = age[i+1];
      assign r_flg = flg[i+1];
    end

    mbpf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .AGE_BITS   (AGE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .sample_i    (sample_i),
      .evict_age_i (evict_age_i),
      .valid_next_i(valid_next),
      .l_val_i     (l_val),
      .l_age_i     (l_age),
      .l_flg_i     (l_flg),
      .r_val_i     (r_val),
      .r_age_i     (r_age),
      .r_flg_i     (r_flg),
      .rem_i       (rem_in),
      .val_o       (val[i]),
      .age_o       (age[i]),
      .flg_o       (flg[i]),
      .rem_o       (rem[i])
    );
  end

  assign med_val_o = val[med_idx_i];

endmodule

/* design/median_baseline_pulse_finder.sv */
// Top level of the moving median baseline pulse finder.
//
// Input channel: sample_i/last_i with in_valid_i, accepted when in_stall_o is
// low. Output channel: pulse_start_o, pulse_end_o, baseline_o, status_o with
// out_valid_o, taken when out_stall_i is low. Zero or one result per sample.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// write only while no sample is in flight.
// In the accept cycle a sample is sorted into the cell chain (oldest entry
// dropped once the window is full, new one inserted); the EVAL state then
// reads the median and runs the baseline, threshold and tail checks, and the
// result is registered when it fires. No new sample is taken during EVAL.
// A result waiting in the output register does not block acceptance of the
// next sample, but evaluation waits while that result is still stalled.
// Reset empties the window, restarts the sample counter at index_offset and
// loads the register defaults. After every result the window refills.
module median_baseline_pulse_finder import mbpf_pkg::*; #(
  parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   pulse_start_o,
  output logic signed [33:0]            pulse_end_o,
  output logic signed [SAMPLE_BITS-1:0] baseline_o,
  output logic [2:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned DW = 34;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } seq_e;

  typedef enum logic [2:0] {
    PH_FILL   = 3'b001,
    PH_SEARCH = 3'b010,
    PH_TAIL   = 3'b100
  } phase_e;

  seq_e   st_q, st_d;
  phase_e phase_q, phase_d;

  logic [5:0]         wlen_q;
  logic [15:0]        pad_q, maxlen_q;
  logic signed [16:0] thr_q;
  logic [31:0]        offset_q;

  logic [31:0]        cnt_q, idx_q;
  logic [CW-1:0]      fill_q, fill_d, win_n_q, win_n_d;
  logic [31:0]        start_q, start_d;
  logic signed [SAMPLE_BITS-1:0] base_q, base_d;
  logic [16:0]        quiet_q, quiet_d, span_q, span_d;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic               last_q;

  logic               out_valid_q;
  logic [31:0]        o_start_q;
  logic signed [33:0] o_end_q;
  logic signed [SAMPLE_BITS-1:0] o_base_q;
  logic [2:0]         o_stat_q;

  logic               accept, eval_fire, emit;
  logic [31:0]        em_start;
  logic [16:0]        em_span;
  logic signed [SAMPLE_BITS-1:0] em_base;
  logic [2:0]         em_stat;

  chain_ctl_t         ctl;
  logic [CW-1:0]      new_cnt, n_clamp, n_eff;
  logic [AW-1:0]      med_idx;
  logic signed [SAMPLE_BITS-1:0] med;
  logic signed [DW-1:0] diff;
  logic               loud;
  logic [16:0]        limit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (st_q != ST_IDLE);
  assign accept      = in_valid_i && (st_q == ST_IDLE);
  assign eval_fire   = (st_q == ST_EVAL) && !(out_valid_q && out_stall_i);

  // Chain is updated in the accept cycle; tail samples stay out of the window.
  assign new_cnt   = (phase_q == PH_SEARCH) ? win_n_q : fill_q + 1'b1;
  assign ctl.upd   = accept && (phase_q != PH_TAIL);
  assign ctl.evict = (phase_q == PH_SEARCH);
  assign ctl.flush = eval_fire && emit;
  assign med_idx   = AW'((win_n_q - 1'b1) >> 1);

  mbpf_chain #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS),
    .AGE_BITS   (AW),
    .CNT_BITS   (CW)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sample_i   (sample_i),
    .evict_age_i(AW'(win_n_q - 1'b1)),
    .new_cnt_i  (new_cnt),
    .med_idx_i  (med_idx),
    .med_val_o  (med)
  );

  always_comb begin
    if (wlen_q == '0) begin
      n_clamp = CW'(1);
    end else if (32'(wlen_q) > WINDOW_MAX) begin
      n_clamp = CW'(WINDOW_MAX);
    end else begin
      n_clamp = CW'(wlen_q);
    end
  end
  assign n_eff = (fill_q == '0) ? n_clamp : win_n_q;

  assign diff  = (phase_q == PH_TAIL) ? DW'(smp_q) - DW'(base_q) : DW'(smp_q) - DW'(med);
  assign loud  = diff > DW'(thr_q);
  assign limit = {1'b0, maxlen_q} + {1'b0, pad_q};

  always_comb begin
    phase_d  = phase_q;
    fill_d   = fill_q;
    win_n_d  = win_n_q;
    start_d  = start_q;
    base_d   = base_q;
    quiet_d  = quiet_q;
    span_d   = span_q;
    emit     = 1'b0;
    em_start = idx_q + 32'd1;
    em_span  = 17'd1;
    em_base  = '0;
    em_stat  = STAT_FILL_END;
    unique case (phase_q)
      PH_SEARCH: begin
        em_base = med;
        if (loud) begin
          phase_d = PH_TAIL;
          start_d = idx_q;
          base_d  = med;
          quiet_d = '0;
          span_d  = 17'd1;
        end else if (last_q) begin
          emit    = 1'b1;
          em_stat = STAT_NO_PULSE;
        end
      end
      PH_TAIL: begin
        if (loud) begin
          quiet_d = '0;
        end else if (quiet_q != '1) begin
          quiet_d = quiet_q + 1'b1;
        end
        if (span_q != '1) begin
          span_d = span_q + 1'b1;
        end
      end
      default: begin
        win_n_d = n_eff;
        fill_d  = fill_q + 1'b1;
        if (fill_d >= n_eff) begin
          phase_d = PH_SEARCH;
        end
        if (last_q) begin
          emit = 1'b1;
        end
      end
    endcase
    // Tail end checks, also on the start sample itself.
    if (phase_d == PH_TAIL) begin
      em_start = start_d;
      em_span  = span_d;
      em_base  = base_d;
      if (quiet_d >= {1'b0, pad_q}) begin
        emit    = 1'b1;
        em_stat = STAT_QUIET_END;
      end else if (span_d >= limit) begin
        emit    = 1'b1;
        em_stat = STAT_LEN_LIMIT;
      end else if (last_q) begin
        emit    = 1'b1;
        em_stat = STAT_DATA_END;
      end
    end
    if (emit) begin
      phase_d = PH_FILL;
      fill_d  = '0;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (accept) st_d = ST_EVAL;
      ST_EVAL: if (eval_fire) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_FILL;
      wlen_q      <= 6'd15;
      pad_q       <= 16'd8;
      maxlen_q    <= 16'd256;
      thr_q       <= 17'sd100;
      offset_q    <= '0;
      cnt_q       <= '0;
      fill_q      <= '0;
      win_n_q     <= CW'(1);
      start_q     <= '0;
      base_q      <= '0;
      quiet_q     <= '0;
      span_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WINDOW_LEN:   wlen_q   <= cfg_data_i[5:0];
          CFG_PAD_AFTER:    pad_q    <= cfg_data_i[15:0];
          CFG_MAX_LENGTH:   maxlen_q <= cfg_data_i[15:0];
          CFG_THRESHOLD:    thr_q    <= cfg_data_i[16:0];
          CFG_INDEX_OFFSET: offset_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        cnt_q <= cnt_q + 32'd1;
      end
      if (eval_fire) begin
        phase_q <= phase_d;
        fill_q  <= fill_d;
        win_n_q <= win_n_d;
        start_q <= start_d;
        base_q  <= base_d;
        quiet_q <= quiet_d;
        span_q  <= span_d;
      end
      if (eval_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q  <= sample_i;
      last_q <= last_i;
      idx_q  <= offset_q + cnt_q;
    end
    if (eval_fire && emit) begin
      o_start_q <= em_start;
      o_end_q   <= $signed({2'b00, em_start} + {17'd0, em_span} - {18'd0, pad_q});
      o_base_q  <= em_base;
      o_stat_q  <= em_stat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_start_o = o_start_q;
  assign pulse_end_o   = o_end_q;
  assign baseline_o    = o_base_q;
  assign status_o      = o_stat_q;

`ifndef ASSERT_OFF
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (st_q == ST_EVAL))
    else $error("accepted sample not evaluated");
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == ST_EVAL))
    else $error("result without evaluation");
  a_tail_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TAIL) |-> (span_q != '0) && (quiet_q < span_q))
    else $error("tail counters inconsistent");
  a_fill_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FILL) && (fill_q != '0) |-> (fill_q < win_n_q))
    else $error("fill count beyond window");
`endif

endmodule

/* tb/sv/mbpf_checker.sv */
// Checker for the median baseline pulse finder: predicts results and compares them.
`timescale 1ns / 1ps
module mbpf_checker import mbpf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [15:0]      sample_i,
  input  logic                    last_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [31:0]             pulse_start_i,
  input  logic signed [33:0]      pulse_end_i,
  input  logic signed [15:0]      baseline_i,
  input  logic [2:0]              status_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  output int unsigned             pending_o,
  output int unsigned             errors_o
);

  typedef enum logic [1:0] {FILLING, SEARCHING, IN_TAIL} track_e;

  typedef struct packed {
    logic [31:0] start;
    logic [33:0] stop;
    logic [15:0] base;
    logic [2:0]  status;
  } pulse_t;

  pulse_t pulses_q[$];

  logic [5:0]         win_reg;
  logic [15:0]        pad_reg;
  logic [15:0]        maxlen_reg;
  logic signed [16:0] thr_reg;
  logic [31:0]        offset_reg;

  logic signed [15:0] ring[WINDOW_MAX_DEF];
  int unsigned        fill_cnt, head, win_n;
  track_e             track;
  logic [31:0]        count, start_idx, quiet, span;
  logic signed [15:0] frozen;

  assign pending_o = pulses_q.size();

  function automatic logic signed [15:0] median_now();
    logic signed [15:0] srt[WINDOW_MAX_DEF];
    logic signed [15:0] v;
    int j;
    for (int i = 0; i < win_n; i++) begin
      v = ring[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    return srt[(win_n - 1) / 2];
  endfunction

  task automatic close_pulse(logic [31:0] st, logic [31:0] sp, logic signed [15:0] b,
                             logic [2:0] code);
    pulse_t p;
    longint e;
    e = longint'(st) + longint'(sp) - longint'(pad_reg);
    p.start = st;
    p.stop = e[33:0];
    p.base = b;
    p.status = code;
    pulses_q.push_back(p);
    track = FILLING;
    fill_cnt = 0;
    head = 0;
  endtask

  task automatic check_tail(logic lst);
    if (quiet >= pad_reg) close_pulse(start_idx, span, frozen, STAT_QUIET_END);
    else if (longint'(span) >= longint'(maxlen_reg) + longint'(pad_reg))
      close_pulse(start_idx, span, frozen, STAT_LEN_LIMIT);
    else if (lst) close_pulse(start_idx, span, frozen, STAT_DATA_END);
  endtask

  task automatic take_sample(logic signed [15:0] s, logic lst);
    logic [31:0] idx;
    logic signed [15:0] b;
    idx = offset_reg + count;
    count++;
    case (track)
      SEARCHING: begin
        ring[head] = s;
        head++;
        if (head >= win_n) head = 0;
        b = median_now();
        if (int'(s) - int'(b) > int'(thr_reg)) begin
          start_idx = idx;
          frozen = b;
          quiet = 0;
          span = 1;
          track = IN_TAIL;
          check_tail(lst);
        end else if (lst) begin
          close_pulse(idx + 1, 1, b, STAT_NO_PULSE);
        end
      end
      IN_TAIL: begin
        if (int'(s) - int'(frozen) > int'(thr_reg)) quiet = 0;
        else if (quiet != '1) quiet++;
        if (span != '1) span++;
        check_tail(lst);
      end
      default: begin
        if (fill_cnt == 0) begin
          win_n = (win_reg == 0) ? 1 : (win_reg > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win_reg;
        end
        if (fill_cnt < win_n) begin
          ring[fill_cnt] = s;
          fill_cnt++;
        end
        if (fill_cnt >= win_n) begin
          track = SEARCHING;
          head = 0;
        end
        if (lst) close_pulse(idx + 1, 1, '0, STAT_FILL_END);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pulse_t p;
    if (!rst_ni) begin
      win_reg = 15;
      pad_reg = 8;
      maxlen_reg = 256;
      thr_reg = 100;
      offset_reg = 0;
      fill_cnt = 0;
      head = 0;
      win_n = 1;
      track = FILLING;
      count = 0;
      start_idx = 0;
      quiet = 0;
      span = 0;
      frozen = 0;
      pulses_q.delete();
      errors_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pulses_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors_o++;
        end else begin
          p = pulses_q.pop_front();
          if (pulse_start_i !== p.start) begin
            $error("pulse_start expected %0d got %0d", p.start, pulse_start_i);
            errors_o++;
          end
          if (pulse_end_i !== p.stop) begin
            $error("pulse_end expected %0d got %0d", $signed(p.stop), pulse_end_i);
            errors_o++;
          end
          if (baseline_i !== p.base) begin
            $error("baseline expected %0d got %0d", $signed(p.base), baseline_i);
            errors_o++;
          end
          if (status_i !== p.status) begin
            $error("status expected %0d got %0d", p.status, status_i);
            errors_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WINDOW_LEN:   win_reg = cfg_data_i[5:0];
          CFG_PAD_AFTER:    pad_reg = cfg_data_i[15:0];
          CFG_MAX_LENGTH:   maxlen_reg = cfg_data_i[15:0];
          CFG_THRESHOLD:    thr_reg = cfg_data_i[16:0];
          CFG_INDEX_OFFSET: offset_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) take_sample(sample_i, last_i);
    end
  end

endmodule

/* tb/sv/median_baseline_pulse_finder_tb.sv */
// Testbench top: drives samples and register writes into the pulse finder, gives the verdict.
`timescale 1ns / 1ps
module median_baseline_pulse_finder_tb import mbpf_pkg::*;;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [15:0]      sample_i = '0;
  logic                    last_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b1;
  logic [31:0]             pulse_start_o;
  logic signed [33:0]      pulse_end_o;
  logic signed [15:0]      baseline_o;
  logic [2:0]              status_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [31:0]             cfg_data_i = '0;
  int unsigned             pending, errors;
  bit                      busy_mode = 1'b0;
  int                      level;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  median_baseline_pulse_finder DUT (.*);

  mbpf_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .sample_i, .last_i,
    .out_valid_i(out_valid_o), .out_stall_i, .pulse_start_i(pulse_start_o),
    .pulse_end_i(pulse_end_o), .baseline_i(baseline_o), .status_i(status_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stall before each transaction, none in busy mode.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = busy_mode ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      forever begin
        @(negedge clk_i);
        if (out_valid_o) break;
      end
      @(posedge clk_i);
    end
  end

  task automatic send_sample(int s, bit lst);
    int n;
    n = busy_mode ? 0 : $urandom_range(0, 9);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= (s > 32767) ? 16'sd32767 : (s < -32768) ? -16'sd32768 : 16'(s);
    last_i <= lst;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
  endtask

  // Drains all expected results, then leaves room for a sample with no result.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic set_regs(int w, int pad, int mx, int thr, logic [31:0] off);
    wait_idle();
    write_reg(CFG_WINDOW_LEN, w);
    write_reg(CFG_PAD_AFTER, pad);
    write_reg(CFG_MAX_LENGTH, mx);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_INDEX_OFFSET, off);
    cfg_valid_i <= 1'b0;
  endtask

  // Noisy baseline with occasional pulses, wild values and record ends.
  task automatic random_record(int cnt);
    int amp, len;
    while (cnt > 0) begin
      if ($urandom_range(0, 29) == 0) level = $urandom_range(0, 50000) - 25000;
      if ($urandom_range(0, 24) == 0) begin
        amp = $urandom_range(50, 8000);
        len = $urandom_range(1, 8);
        repeat (len) begin
          send_sample(level + amp + $urandom_range(0, 40) - 20, 1'b0);
          cnt--;
        end
      end else if ($urandom_range(0, 29) == 0) begin
        send_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 59) == 0);
        cnt--;
      end else begin
        send_sample(level + $urandom_range(0, 40) - 20, $urandom_range(0, 59) == 0);
        cnt--;
      end
    end
  endtask

  initial begin
    int w, pad, mx, thr;
    logic [31:0] off;
    level = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: end during fill, close on the start sample, no-pulse end, extremes.
    set_regs(1, 0, 1, 0, 32'hFFFF_FFFE);
    send_sample(5, 1'b1);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(-32768, 1'b1);
    set_regs(3, 2, 4, 10, 0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b1);
    send_sample(1, 1'b0);
    send_sample(2, 1'b0);
    send_sample(3, 1'b0);
    send_sample(4, 1'b1);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(500, 1'b0);
    send_sample(500, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(600, 1'b0);
    send_sample(600, 1'b1);
    set_regs(0, 65535, 0, -65536, 0);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b1);

    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin w = 32; pad = 0; mx = 65535; thr = 65535; off = '1; end
        1: begin w = 63; pad = 3; mx = 1; thr = 200; off = 100; end
        2: begin w = 2; pad = 65535; mx = 5; thr = -65536; off = 32'hFFFF_FF00; end
        default: begin
          w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 16);
          pad = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 10);
          mx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 30);
          thr = $urandom_range(0, 7) == 0 ? $urandom_range(0, 131071) - 65536
                                          : $urandom_range(0, 600) - 50;
          off = {$urandom()};
        end
      endcase
      busy_mode = (ph % 4 == 3);
      set_regs(w, pad, mx, thr, off);
      random_record(64);
      send_sample(level, 1'b1);
    end
    busy_mode = 1'b0;

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
